// ===== rtl/thermal_pixel_correction_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the thermal pixel correction unit
// ----------------------------------------------------------------------------
`ifndef THERMAL_PIXEL_CORRECTION_UNIT_MACROS_SVH
`define THERMAL_PIXEL_CORRECTION_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpc assertion failed");

// Next-cycle implication, disabled during reset
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpc assertion failed");

`endif

// ===== rtl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and the Q15 rounding helper of the pixel corrector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

  // Planck table geometry
  localparam int TABLE_DEPTH = 65536;
  localparam int TABLE_AW    = 16;
  localparam int WORD_W      = 16;

  // Pipeline stages in the front part, decoupling queue depth
  localparam int FRONT_STAGES        = 3;
  localparam int QUEUE_DEPTH_DEFAULT = 8;

  // Configuration
  localparam logic [15:0] FLAG_REF_RESET = 16'h0a39;
  localparam logic        FLAG_REF_IDX   = 1'b0;
  localparam int          PADDR_W        = 3;

  // Commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TABLE = 1'b1;

  // One unit of work handed from front to back
  typedef struct packed {
    logic                cmd;
    logic [TABLE_AW-1:0] addr;
    logic [WORD_W-1:0]   data;
  } tpc_entry_t;

  // Round, double and saturate a signed 16x16 product to Q15.
  // (2ab + 2^15) >> 16 equals (ab + 2^14) >> 15; only +32768 can overflow.
  function automatic logic [WORD_W-1:0] q15_round_sat(input logic signed [31:0] prod);
    logic signed [31:0] t;
    t = prod + 32'sd16384;
    if (t[31:15] == 17'h08000) begin
      return 16'h7fff;
    end
    return t[30:15];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tpc_front.sv =====
// ----------------------------------------------------------------------------
// tpc_front
// Accepts items and runs the correction arithmetic in three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_front
  import tpc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic                command,
  input  wire logic [15:0]         raw_sample,
  input  wire logic [15:0]         dark_level,
  input  wire logic signed [15:0]  gain_q15,
  input  wire logic signed [15:0]  emissivity_q15,
  input  wire logic [15:0]         pixel_offset,
  input  wire logic [15:0]         table_index,
  input  wire logic [15:0]         table_value,
  input  wire logic [15:0]         flag_reference,
  output logic                     push,
  output tpc_entry_t               push_entry,
  output logic [$clog2(FRONT_STAGES+1)-1:0] inflight
);

  // Stage valid bits
  logic s0_valid, s1_valid, s2_valid;

  // Stage payloads
  logic               s0_cmd, s1_cmd, s2_cmd;
  logic signed [15:0] s0_diff, s0_gain, s0_emis, s1_emis;
  logic [15:0]        s0_offset, s1_offset, s2_offset;
  logic [15:0]        s0_tidx, s1_tidx, s2_tidx;
  logic [15:0]        s0_tval, s1_tval, s2_tval;
  logic signed [31:0] s1_prod, s2_prod;
  logic [15:0]        corrected;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
    end
  end

  // Stage 0: capture, dark subtraction with wrap
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_cmd    <= command;
      s0_diff   <= raw_sample - dark_level;
      s0_gain   <= gain_q15;
      s0_emis   <= emissivity_q15;
      s0_offset <= pixel_offset;
      s0_tidx   <= table_index;
      s0_tval   <= table_value;
    end
  end

  // Stage 1: gain product
  always_ff @(posedge clk) begin
    s1_cmd    <= s0_cmd;
    s1_prod   <= s0_diff * s0_gain;
    s1_emis   <= s0_emis;
    s1_offset <= s0_offset;
    s1_tidx   <= s0_tidx;
    s1_tval   <= s0_tval;
  end

  // Stage 2: round the gain product, emissivity product
  always_ff @(posedge clk) begin
    s2_cmd    <= s1_cmd;
    s2_prod   <= $signed(q15_round_sat(s1_prod)) * s1_emis;
    s2_offset <= s1_offset;
    s2_tidx   <= s1_tidx;
    s2_tval   <= s1_tval;
  end

  // Round, add flag reference and pixel offset (wrapping)
  assign corrected = q15_round_sat(s2_prod) + flag_reference + s2_offset;

  // Hand over to the queue
  assign push            = s2_valid;
  assign push_entry.cmd  = s2_cmd;
  assign push_entry.addr = (s2_cmd == CMD_TABLE) ? s2_tidx : corrected;
  assign push_entry.data = s2_tval;

  assign inflight = ($clog2(FRONT_STAGES+1))'(s0_valid)
                  + ($clog2(FRONT_STAGES+1))'(s1_valid)
                  + ($clog2(FRONT_STAGES+1))'(s2_valid);

endmodule

`default_nettype wire

// ===== rtl/tpc_queue.sv =====
// ----------------------------------------------------------------------------
// tpc_queue
// Short FIFO between the arithmetic front and the table back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_queue
  import tpc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire tpc_entry_t               push_entry,
  input  wire logic                     pop,
  output tpc_entry_t                    head,
  output logic                          empty,
  output logic [$clog2(DEPTH+1)-1:0]    count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tpc_entry_t            slots [DEPTH];
  logic [PW-1:0]         wr_ptr, rd_ptr;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + ($clog2(DEPTH+1))'(push) - ($clog2(DEPTH+1))'(pop);
    end
  end

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);

endmodule

`default_nettype wire

// ===== rtl/tpc_back.sv =====
// ----------------------------------------------------------------------------
// tpc_back
// Planck table: applies table writes and looks up corrected pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_back
  import tpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        exec,
  input  wire tpc_entry_t  entry,
  output logic             done,
  output logic [15:0]      temperature_code
);

  logic [WORD_W-1:0] planck_mem [TABLE_DEPTH];

  // Single port: write for table commands, registered read for pixels
  always_ff @(posedge clk) begin
    if (exec) begin
      if (entry.cmd == CMD_TABLE) begin
        planck_mem[entry.addr] <= entry.data;
      end else begin
        temperature_code <= planck_mem[entry.addr];
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec && (entry.cmd == CMD_PIXEL);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/thermal_pixel_correction_unit.sv =====
// ----------------------------------------------------------------------------
// thermal_pixel_correction_unit
// Thermal pixel correction: dark, gain, emissivity, offset and Planck lookup.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  input     start / busy               command, raw_sample .. table_value
//  result    done (one-cycle strobe)    temperature_code
//  config    APB psel/penable/pwrite    flag_reference at address 0
//
//  One item is accepted per clock while busy is low. A pixel result is
//  strobed once its transfer has passed three arithmetic stages, the queue,
//  and the registered read of the single-port Planck table, which executes
//  one command per cycle. The back drains one entry per cycle, so the queue
//  never holds more than one entry and busy does not rise at the default depth.
//  Reset clears control state; the table is undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "thermal_pixel_correction_unit_macros.svh"

module thermal_pixel_correction_unit
  import tpc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command,
  input  wire logic [15:0]        raw_sample,
  input  wire logic [15:0]        dark_level,
  input  wire logic signed [15:0] gain_q15,
  input  wire logic signed [15:0] emissivity_q15,
  input  wire logic [15:0]        pixel_offset,
  input  wire logic [15:0]        table_index,
  input  wire logic [15:0]        table_value,
  // result channel
  output logic                    done,
  output logic [15:0]             temperature_code,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CW  = $clog2(QUEUE_DEPTH+1);
  localparam int IW  = $clog2(FRONT_STAGES+1);
  localparam int OCW = $clog2(QUEUE_DEPTH+FRONT_STAGES+1);

  logic              accept;
  logic [15:0]       flag_reference;
  logic              push, pop, q_empty;
  tpc_entry_t        push_entry, head;
  logic [CW-1:0]     q_count;
  logic [IW-1:0]     inflight;
  logic [OCW-1:0]    occupancy;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_reference <= FLAG_REF_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == FLAG_REF_IDX)) begin
      flag_reference <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == FLAG_REF_IDX) ? {16'h0000, flag_reference} : 32'h0;

  // Admission: room in the queue for every item already in flight
  assign occupancy = OCW'(q_count) + OCW'(inflight);
  assign busy      = (occupancy >= OCW'(QUEUE_DEPTH));
  assign accept    = start && !busy;

  tpc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .command        (command),
    .raw_sample     (raw_sample),
    .dark_level     (dark_level),
    .gain_q15       (gain_q15),
    .emissivity_q15 (emissivity_q15),
    .pixel_offset   (pixel_offset),
    .table_index    (table_index),
    .table_value    (table_value),
    .flag_reference (flag_reference),
    .push           (push),
    .push_entry     (push_entry),
    .inflight       (inflight)
  );

  tpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .count      (q_count)
  );

  // Back part drains one entry per cycle while the queue is not empty
  assign pop = !q_empty;

  tpc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .exec             (pop),
    .entry            (head),
    .done             (done),
    .temperature_code (temperature_code)
  );

  // Checks
  `TPC_ASSERT_NOW(a_no_overflow, clk, rst, push, q_count != CW'(QUEUE_DEPTH) || pop)
  `TPC_ASSERT_NOW(a_occupancy_bound, clk, rst, 1'b1, occupancy <= OCW'(QUEUE_DEPTH))
  `TPC_ASSERT_NEXT(a_result_from_pixel, clk, rst, pop && (head.cmd == CMD_PIXEL), done)
  `TPC_ASSERT_NEXT(a_no_spurious_result, clk, rst, !pop || (head.cmd == CMD_TABLE), !done)

endmodule

`default_nettype wire

// ===== bench/tb_thermal_pixel_correction_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermal_pixel_correction_unit
// Self-checking bench for the thermal pixel correction unit. A scripted set of
// table loads and pixels covers the extremes, Q15 saturation, dark wrap and
// table overwrites. Random traffic then runs under several flag reference
// settings and sender idle rates. Each pixel result is predicted from a local
// copy of the Planck table and of the flag reference, or is hand-written in a
// scripted row. Pixels only look up entries the bench has already loaded.
// ----------------------------------------------------------------------------

module tb_thermal_pixel_correction_unit;
  import tpc_pkg::*;

  localparam int PIXEL_LATENCY    = 6;
  localparam int SETTLE_CYCLES    = PIXEL_LATENCY + 4;
  localparam int DRAIN_LIMIT      = 2000;
  localparam int RANDOM_PER_PHASE = 545;
  localparam int RUN_LIMIT_NS     = 20_000_000;

  localparam logic [PADDR_W-1:0] FLAG_REF_ADDR = PADDR_W'(4 * int'(FLAG_REF_IDX));
  // address of register index 1, which does not exist
  localparam logic [PADDR_W-1:0] SPARE_ADDR    = PADDR_W'(4);

  // One command transfer
  typedef struct packed {
    logic               command;
    logic [15:0]        raw_sample;
    logic [15:0]        dark_level;
    logic signed [15:0] gain_q15;
    logic signed [15:0] emissivity_q15;
    logic [15:0]        pixel_offset;
    logic [15:0]        table_index;
    logic [15:0]        table_value;
  } cmd_item_t;

  // Scripted row: aim steers the offset onto table_index, typed carries a
  // hand-written temperature code
  typedef struct packed {
    cmd_item_t   item;
    logic        aim;
    logic        typed;
    logic [15:0] code;
  } script_row_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        start          = 1'b0;
  logic        command        = CMD_PIXEL;
  logic [15:0] raw_sample     = '0;
  logic [15:0] dark_level     = '0;
  logic signed [15:0] gain_q15       = '0;
  logic signed [15:0] emissivity_q15 = '0;
  logic [15:0] pixel_offset   = '0;
  logic [15:0] table_index    = '0;
  logic [15:0] table_value    = '0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0] pwdata         = '0;
  wire         busy;
  wire         done;
  wire  [15:0] temperature_code;
  wire  [31:0] prdata;
  wire         pready;

  // Predictor state
  logic [15:0] planck_shadow [TABLE_DEPTH];
  bit          entry_loaded  [TABLE_DEPTH];
  logic [15:0] loaded_index [$];
  logic [15:0] flag_ref_model = FLAG_REF_RESET;

  logic [15:0] code_queue [$];
  logic [15:0] code_want;
  int          fail_count = 0;
  int          gap_pct    = 0;

  localparam script_row_t SCRIPT [16] = '{
    // table loads, pixel fields unused
    '{'{CMD_TABLE, 16'hffff, 16'h8000, 16'sh7fff, 16'sh8000, 16'hffff, 16'h0a39, 16'h1234},
      1'b0, 1'b0, 16'h0000},
    '{'{CMD_TABLE, 16'h0000, 16'hffff, 16'sh8000, 16'sh7fff, 16'h0000, 16'h0000, 16'hffff},
      1'b0, 1'b0, 16'h0000},
    '{'{CMD_TABLE, 16'h5555, 16'haaaa, 16'sh0001, 16'shffff, 16'haaaa, 16'hffff, 16'h0000},
      1'b0, 1'b0, 16'h0000},
    '{'{CMD_TABLE, 16'h0001, 16'h0000, 16'sh0000, 16'sh0000, 16'h0001, 16'h8000, 16'h5a5a},
      1'b0, 1'b0, 16'h0000},
    // all-zero pixel lands on the reset flag reference
    '{'{CMD_PIXEL, 16'h0000, 16'h0000, 16'sh0000, 16'sh0000, 16'h0000, 16'hffff, 16'hffff},
      1'b0, 1'b1, 16'h1234},
    // offset wraps the sum to zero, then to the top entry
    '{'{CMD_PIXEL, 16'hffff, 16'hffff, 16'sh7fff, 16'sh7fff, 16'hf5c7, 16'hffff, 16'hffff},
      1'b0, 1'b1, 16'hffff},
    '{'{CMD_PIXEL, 16'h1234, 16'h1234, 16'sh8000, 16'sh8000, 16'hf5c6, 16'h0000, 16'h0000},
      1'b0, 1'b1, 16'h0000},
    // gain saturation: diff -32768 times gain -32768
    '{'{CMD_PIXEL, 16'h8000, 16'h0000, 16'sh8000, 16'sh7fff, 16'h0000, 16'h8000, 16'hffff},
      1'b1, 1'b0, 16'h0000},
    '{'{CMD_PIXEL, 16'h8000, 16'h0000, 16'sh8000, 16'sh8000, 16'h0000, 16'h0000, 16'hffff},
      1'b1, 1'b0, 16'h0000},
    // dark level above raw wraps negative, then mixed-sign extremes
    '{'{CMD_PIXEL, 16'h0000, 16'h0001, 16'sh7fff, 16'sh7fff, 16'h0000, 16'hffff, 16'h0000},
      1'b1, 1'b0, 16'h0000},
    '{'{CMD_PIXEL, 16'hffff, 16'h0000, 16'sh8000, 16'sh0001, 16'h0000, 16'h0a39, 16'hffff},
      1'b1, 1'b0, 16'h0000},
    '{'{CMD_PIXEL, 16'h7fff, 16'h8000, 16'sh4000, 16'shc000, 16'h0000, 16'h8000, 16'h0000},
      1'b1, 1'b0, 16'h0000},
    '{'{CMD_PIXEL, 16'h7fff, 16'h0000, 16'sh7fff, 16'sh8000, 16'h0000, 16'h0000, 16'hffff},
      1'b1, 1'b0, 16'h0000},
    // overwrite an entry and read it back
    '{'{CMD_TABLE, 16'hffff, 16'hffff, 16'shffff, 16'shffff, 16'hffff, 16'h0a39, 16'habcd},
      1'b0, 1'b0, 16'h0000},
    '{'{CMD_PIXEL, 16'h5555, 16'haaaa, 16'sh0001, 16'shffff, 16'h0000, 16'h0a39, 16'h0000},
      1'b1, 1'b0, 16'h0000},
    '{'{CMD_PIXEL, 16'h0000, 16'h0000, 16'sh0000, 16'sh0000, 16'h0000, 16'h0000, 16'h0000},
      1'b0, 1'b1, 16'habcd}
  };

  thermal_pixel_correction_unit DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .raw_sample       (raw_sample),
    .dark_level       (dark_level),
    .gain_q15         (gain_q15),
    .emissivity_q15   (emissivity_q15),
    .pixel_offset     (pixel_offset),
    .table_index      (table_index),
    .table_value      (table_value),
    .done             (done),
    .temperature_code (temperature_code),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #10 clk = ~clk;

  // Rounding, doubling Q15 multiply; only -1 * -1 saturates
  function automatic logic [15:0] q15_scale(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
    longint prod;
    longint r;
    prod = 2 * longint'(a) * longint'(b) + 32768;
    r = prod >>> 16;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return r[15:0];
  endfunction

  // Table address reached by a pixel under the current flag reference
  function automatic logic [15:0] lookup_index(input cmd_item_t it);
    logic [15:0] diff;
    logic [15:0] scaled;
    diff   = it.raw_sample - it.dark_level;
    scaled = q15_scale(q15_scale(diff, it.gain_q15), it.emissivity_q15);
    return scaled + flag_ref_model + it.pixel_offset;
  endfunction

  // Offset that moves a pixel onto a chosen table entry
  function automatic logic [15:0] offset_for(input cmd_item_t it, input logic [15:0] target);
    return it.pixel_offset + (target - lookup_index(it));
  endfunction

  function automatic logic [15:0] random_q15();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cmd_item_t random_item(input logic cmd);
    cmd_item_t it;
    it.command        = cmd;
    it.raw_sample     = 16'($urandom);
    it.dark_level     = 16'($urandom);
    it.gain_q15       = random_q15();
    it.emissivity_q15 = random_q15();
    it.pixel_offset   = 16'($urandom);
    it.table_index    = 16'($urandom);
    it.table_value    = 16'($urandom);
    // diff of -32768 now and then, for gain saturation
    if ($urandom_range(0, 7) == 0) begin
      it.raw_sample = it.dark_level + 16'h8000;
    end
    return it;
  endfunction

  // Update the table copy or queue the expected temperature code
  task automatic note_accepted(input cmd_item_t it, input bit typed, input logic [15:0] code);
    logic [15:0] idx;
    if (it.command == CMD_TABLE) begin
      planck_shadow[it.table_index] = it.table_value;
      if (!entry_loaded[it.table_index]) begin
        entry_loaded[it.table_index] = 1'b1;
        loaded_index.push_back(it.table_index);
      end
    end else begin
      idx = lookup_index(it);
      code_queue.push_back(typed ? code : planck_shadow[idx]);
    end
  endtask

  // Hold start low until every result is back and the pipe has emptied
  task automatic wait_results_settled();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (code_queue.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (code_queue.size() != 0) begin
      $error("%0d temperature codes never arrived", code_queue.size());
      fail_count++;
      code_queue.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive one command, wait for its transfer, then maybe idle
  task automatic issue(input cmd_item_t it, input bit typed, input logic [15:0] code);
    start          <= 1'b1;
    command        <= it.command;
    raw_sample     <= it.raw_sample;
    dark_level     <= it.dark_level;
    gain_q15       <= it.gain_q15;
    emissivity_q15 <= it.emissivity_q15;
    pixel_offset   <= it.pixel_offset;
    table_index    <= it.table_index;
    table_value    <= it.table_value;
    do @(posedge clk); while (busy);
    note_accepted(it, typed, code);
    // each following cycle idles with the phase's idle percentage
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    if ($urandom_range(0, 199) == 0) begin
      wait_results_settled();
    end
  endtask

  // APB write, then read the flag reference back
  task automatic program_flag(input logic [PADDR_W-1:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == FLAG_REF_ADDR) begin
      flag_ref_model = value;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FLAG_REF_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== flag_ref_model) begin
      $error("flag_reference readback: expected %h, actual %h", flag_ref_model, prdata[15:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: pixels only ever read loaded entries
  task automatic random_burst(input int count);
    cmd_item_t it;
    cmd_item_t load;
    logic [15:0] idx;
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        it = random_item(CMD_TABLE);
        if ($urandom_range(0, 2) == 0) begin
          it.table_index = loaded_index[$urandom_range(0, loaded_index.size() - 1)];
        end
        issue(it, 1'b0, '0);
        sent++;
      end else begin
        it = random_item(CMD_PIXEL);
        if ($urandom_range(0, 1) == 0) begin
          it.pixel_offset =
            offset_for(it, loaded_index[$urandom_range(0, loaded_index.size() - 1)]);
        end
        idx = lookup_index(it);
        if (!entry_loaded[idx]) begin
          load             = random_item(CMD_TABLE);
          load.table_index = idx;
          issue(load, 1'b0, '0);
          sent++;
        end
        issue(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Result checker: done is a one-cycle strobe, no back-pressure
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (code_queue.size() == 0) begin
        $error("unexpected result, temperature_code %h", temperature_code);
        fail_count++;
      end else begin
        code_want = code_queue.pop_front();
        if (temperature_code !== code_want) begin
          $error("temperature_code: expected %h, actual %h", code_want, temperature_code);
          fail_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    cmd_item_t it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // scripted part under the reset flag reference
    gap_pct = 19;
    foreach (SCRIPT[i]) begin
      it = SCRIPT[i].item;
      if (SCRIPT[i].aim) begin
        it.pixel_offset = offset_for(it, SCRIPT[i].item.table_index);
      end
      issue(it, SCRIPT[i].typed, SCRIPT[i].code);
    end

    // random phases, each under its own flag reference and idle rate
    for (int ph = 0; ph < 3; ph++) begin
      wait_results_settled();
      case (ph)
        0: begin
          program_flag(FLAG_REF_ADDR, 16'h0000);
          program_flag(SPARE_ADDR, 16'($urandom));
          gap_pct = 19;
        end
        1: begin
          program_flag(FLAG_REF_ADDR, 16'hffff);
          gap_pct = 53;
        end
        default: begin
          program_flag(FLAG_REF_ADDR, 16'($urandom));
          gap_pct = 0;
        end
      endcase
      random_burst(RANDOM_PER_PHASE);
    end

    wait_results_settled();
    if (fail_count == 0) begin
      $display("tb_thermal_pixel_correction_unit: PASS");
    end else begin
      $display("tb_thermal_pixel_correction_unit: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_thermal_pixel_correction_unit: FAIL");
    $finish;
  end

endmodule

// ===== thermal_pixel_correction_unit.f =====
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tpc_front.sv
rtl/tpc_queue.sv
rtl/tpc_back.sv
rtl/thermal_pixel_correction_unit.sv
bench/tb_thermal_pixel_correction_unit.sv
